/* rtl/mlpf_pkg.sv */
// ---------------------------------------------------------------------------
// mlpf_pkg - shared types and constants for the multilevel priority FIFO
// Item formats, operation and status codes, ring pointer helper.
// ---------------------------------------------------------------------------
`default_nettype none

package mlpf_pkg;

  localparam int LEVELS    = 16;
  localparam int DEPTH     = 8;
  localparam int LEVEL_W   = $clog2(LEVELS);
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int ADDR_W    = LEVEL_W + PTR_W;
  localparam int MEM_WORDS = LEVELS * (2 ** PTR_W);
  localparam int DATA_W    = 32;
  localparam int PRI_W     = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PEEK   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DATA_W-1:0] data_in;
    logic [PRI_W-1:0]        priority_req;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]              status;
    logic                    all_empty;
    logic                    level_empty;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* rtl/mlpf_ctrl.sv */
// ---------------------------------------------------------------------------
// mlpf_ctrl - sequencer for the multilevel priority FIFO
// Accepts an item, runs the execute state, then presents the result.
// ---------------------------------------------------------------------------
`default_nettype none

module mlpf_ctrl
  import mlpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output ctrl_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy   = (state == ST_EXEC);
  assign done   = (state == ST_RESP);
  assign accept = start && !busy;

  assign cmd.load = accept;
  assign cmd.exec = (state == ST_EXEC);

  always_comb begin
    case (state)
      ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_RESP;
      // a new item may be taken while the result is shown
      ST_RESP: state_next = accept ? ST_EXEC : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/mlpf_dp.sv */
// ---------------------------------------------------------------------------
// mlpf_dp - datapath of the multilevel priority FIFO
// Per-level ring pointers, occupancy flags, priority encoder, entry memory.
// ---------------------------------------------------------------------------
`default_nettype none

module mlpf_dp
  import mlpf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ctrl_cmd_t cmd,
  input  wire in_item_t  request,
  output out_item_t      result
);

  in_item_t            req_q;
  logic [LEVELS-1:0]   occ;
  logic [LEVELS-1:0]   occ_next;
  logic [PTR_W-1:0]    head [LEVELS];
  logic [PTR_W-1:0]    tail [LEVELS];
  logic [DATA_W-1:0]   mem [MEM_WORDS];
  logic [DATA_W-1:0]   rdata_q;

  logic                valid_pri;
  logic [LEVEL_W-1:0]  lvl_req;
  logic [LEVEL_W-1:0]  top;
  logic                any_occ;
  logic [LEVEL_W-1:0]  sel;
  logic [PTR_W-1:0]    head_s;
  logic [PTR_W-1:0]    tail_s;
  logic                ptr_we;
  logic [PTR_W-1:0]    head_new;
  logic [PTR_W-1:0]    tail_new;
  logic                mem_we;
  logic                mem_re;
  logic [PTR_W-1:0]    wptr;
  logic [1:0]          status_next;
  logic                rd_ok_next;
  logic                lvl_empty_next;

  logic [1:0]          status_q;
  logic                rd_ok_q;
  logic                all_empty_q;
  logic                lvl_empty_q;

  // low bits of priority minus one; out-of-range values are caught by valid_pri
  assign lvl_req   = req_q.priority_req[LEVEL_W-1:0] - LEVEL_W'(1);
  assign valid_pri = (req_q.priority_req != '0) && (32'(req_q.priority_req) <= LEVELS);
  assign any_occ   = |occ;

  // highest occupied level wins
  always_comb begin
    top = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (occ[i]) top = LEVEL_W'(i);
    end
  end

  assign sel    = (req_q.op == OP_INSERT) ? lvl_req : top;
  assign head_s = head[sel];
  assign tail_s = tail[sel];

  always_comb begin
    occ_next    = occ;
    ptr_we      = 1'b0;
    head_new    = head_s;
    tail_new    = tail_s;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wptr        = '0;
    status_next = STAT_OK;
    rd_ok_next  = 1'b0;
    case (req_q.op)
      OP_INSERT: begin
        if (!valid_pri) begin
          status_next = STAT_BAD;
        end else if (!occ[sel]) begin
          occ_next[sel] = 1'b1;
          ptr_we        = 1'b1;
          head_new      = '0;
          tail_new      = '0;
          mem_we        = 1'b1;
          wptr          = '0;
        end else if (ring_next(tail_s) == head_s) begin
          status_next = STAT_FULL;
        end else begin
          ptr_we   = 1'b1;
          tail_new = ring_next(tail_s);
          mem_we   = 1'b1;
          wptr     = ring_next(tail_s);
        end
      end
      OP_PEEK, OP_REMOVE: begin
        if (!any_occ) begin
          status_next = STAT_EMPTY;
        end else begin
          mem_re     = 1'b1;
          rd_ok_next = 1'b1;
          if (req_q.op == OP_REMOVE) begin
            ptr_we = 1'b1;
            if (head_s == tail_s) begin
              // level drains
              occ_next[sel] = 1'b0;
              head_new      = '0;
              tail_new      = '0;
            end else begin
              head_new = ring_next(head_s);
            end
          end
        end
      end
      default: begin
      end
    endcase
    lvl_empty_next = !valid_pri || !occ_next[lvl_req];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else if (cmd.exec) begin
      occ <= occ_next;
      if (ptr_we) begin
        head[sel] <= head_new;
        tail[sel] <= tail_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q    <= status_next;
      rd_ok_q     <= rd_ok_next;
      all_empty_q <= (occ_next == '0);
      lvl_empty_q <= lvl_empty_next;
    end
  end

  // entry memory: one write or one read per execute cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[{sel, wptr}] <= req_q.data_in;
    end
    if (cmd.exec && mem_re) begin
      rdata_q <= mem[{sel, head_s}];
    end
  end

  assign result.data_out    = rd_ok_q ? rdata_q : '0;
  assign result.status      = status_q;
  assign result.all_empty   = all_empty_q;
  assign result.level_empty = lvl_empty_q;

endmodule

`default_nettype wire

/* rtl/multilevel_priority_fifo.sv */
// ---------------------------------------------------------------------------
// multilevel_priority_fifo - priority queue of one ring buffer per level
// Insert to a level, peek or remove the oldest entry of the highest level.
// ---------------------------------------------------------------------------
//  Channel   Ports                 Handshake
//  -------   -------------------   ------------------------------------
//  request   start, busy, request  taken on a clock edge with start & !busy
//  result    done, result          valid for the single cycle done is high
//
//  An item is taken in the accept cycle, then the execute state
//  updates the level's pointers and makes the single entry memory access.
//  The result is shown in the following cycle, during which the next item
//  may already be accepted.
//  Synchronous reset empties every level; the entry memory is not cleared.
//  The receiver cannot stall: each result is shown once for one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_fifo
  import mlpf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t request,
  output logic          done,
  output out_item_t     result
);

  ctrl_cmd_t cmd;

  mlpf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mlpf_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .result  (result)
  );

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while executing");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item not executed");

  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("execute cycle not followed by a result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_EMPTY) |-> (result.all_empty && result.data_out == '0))
    else $error("empty queue result inconsistent");

  a_bad_pri: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_BAD) |-> result.level_empty)
    else $error("bad priority reported a non-empty level");

endmodule

`default_nettype wire
